[hw/rtl/sssp_pkg.sv]
package sssp_pkg;

    localparam int MAX_NODES     = 64;
    localparam int NODE_BITS     = 6;
    localparam int NCOUNT_BITS   = 7;
    localparam int MAX_EDGES     = 256;
    localparam int EDGE_IDX_BITS = 8;
    localparam int EDGE_CNT_BITS = 9;
    localparam int WEIGHT_BITS   = 16;
    localparam int DIST_BITS     = 22;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 7;
    localparam int STEP_BITS     = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_NODE = 1'd1;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    localparam logic [NCOUNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic                   req_type;
        logic [NODE_BITS-1:0]   end_a;
        logic [NODE_BITS-1:0]   end_b;
        logic [WEIGHT_BITS-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [NODE_BITS-1:0] node_index;
        logic                 reachable;
        logic [DIST_BITS-1:0] distance;
        logic                 store_overflow;
        logic                 last_result;
    } t_out_item;

    typedef struct packed {
        logic [NODE_BITS-1:0]   a;
        logic [NODE_BITS-1:0]   b;
        logic [WEIGHT_BITS-1:0] w;
    } t_edge;

    // Jump conditions: when true the sequencer jumps to the target step,
    // otherwise it falls through to the next step.
    localparam logic [2:0] C_NEVER      = 3'd0;
    localparam logic [2:0] C_ALWAYS     = 3'd1;
    localparam logic [2:0] C_NO_RUN     = 3'd2;
    localparam logic [2:0] C_EDGES_DONE = 3'd3;
    localparam logic [2:0] C_SKIP_EDGE  = 3'd4;
    localparam logic [2:0] C_PASS_MORE  = 3'd5;
    localparam logic [2:0] C_OUT_BUSY   = 3'd6;
    localparam logic [2:0] C_EMIT_MORE  = 3'd7;

    typedef struct packed {
        logic [2:0]           cond;
        logic [STEP_BITS-1:0] target;
        logic                 in_rdy;
        logic                 init;
        logic                 edge_rd;
        logic                 dist_rd;
        logic                 relax_ab;
        logic                 relax_ba;
        logic                 next_pass;
        logic                 emit_rd;
        logic                 emit_ld;
        logic                 emit_inc;
        logic                 finish;
    } t_ucode;

    localparam logic [STEP_BITS-1:0] S_IDLE      = 4'd0;
    localparam logic [STEP_BITS-1:0] S_INIT      = 4'd1;
    localparam logic [STEP_BITS-1:0] S_EDGE_RD   = 4'd2;
    localparam logic [STEP_BITS-1:0] S_DIST_RD   = 4'd3;
    localparam logic [STEP_BITS-1:0] S_RELAX_AB  = 4'd4;
    localparam logic [STEP_BITS-1:0] S_RELAX_BA  = 4'd5;
    localparam logic [STEP_BITS-1:0] S_PASS_END  = 4'd6;
    localparam logic [STEP_BITS-1:0] S_EMIT_RD   = 4'd7;
    localparam logic [STEP_BITS-1:0] S_EMIT_LD   = 4'd8;
    localparam logic [STEP_BITS-1:0] S_EMIT_NEXT = 4'd9;
    localparam logic [STEP_BITS-1:0] S_FINISH    = 4'd10;

    function automatic t_ucode ucode_rom(input logic [STEP_BITS-1:0] step);
        t_ucode w;
        w = '0;
        case (step)
            S_IDLE: begin
                w.cond = C_NO_RUN;    w.target = S_IDLE;    w.in_rdy = 1'b1;
            end
            S_INIT: begin
                w.cond = C_NEVER;     w.target = S_IDLE;    w.init = 1'b1;
            end
            S_EDGE_RD: begin
                w.cond = C_EDGES_DONE; w.target = S_PASS_END; w.edge_rd = 1'b1;
            end
            S_DIST_RD: begin
                w.cond = C_SKIP_EDGE; w.target = S_EDGE_RD; w.dist_rd = 1'b1;
            end
            S_RELAX_AB: begin
                w.cond = C_NEVER;     w.target = S_IDLE;    w.relax_ab = 1'b1;
            end
            S_RELAX_BA: begin
                w.cond = C_ALWAYS;    w.target = S_EDGE_RD; w.relax_ba = 1'b1;
            end
            S_PASS_END: begin
                w.cond = C_PASS_MORE; w.target = S_EDGE_RD; w.next_pass = 1'b1;
            end
            S_EMIT_RD: begin
                w.cond = C_NEVER;     w.target = S_IDLE;    w.emit_rd = 1'b1;
            end
            S_EMIT_LD: begin
                w.cond = C_OUT_BUSY;  w.target = S_EMIT_LD; w.emit_ld = 1'b1;
            end
            S_EMIT_NEXT: begin
                w.cond = C_EMIT_MORE; w.target = S_EMIT_RD; w.emit_inc = 1'b1;
            end
            S_FINISH: begin
                w.cond = C_ALWAYS;    w.target = S_IDLE;    w.finish = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS;    w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/single_source_shortest_path_core.sv]
// Single-source shortest path engine for undirected graphs of up to 64 nodes
// with nonnegative 16-bit weights. Edge beats (req_type 0) load one edge per
// cycle while the block is idle into a 256-entry edge store; edges naming a
// node at or above node_count (zero acts as one) are dropped silently, and
// edges past the store's capacity are dropped and reported through
// store_overflow on the next run. A run beat (req_type 1) relaxes every stored
// in-range edge in both directions, pass after pass, until a pass changes
// nothing or node_count passes are done, then emits one result beat per node
// 0..node_count-1 (last_result on the final one) and empties the edge store.
// Distances saturate at 4194303. A small microcode program steps the
// datapath; the distance memory has a single write port (one direction
// relaxed per cycle), the edge and distance memories have registered reads,
// and an end-of-store check closes each pass.
// Input is not taken while a run is in progress. Configuration writes are
// taken at any time but must only be issued while the block is idle.
module single_source_shortest_path_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  sssp_pkg::t_in_item                        i_in_item,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output sssp_pkg::t_out_item                       o_out_item,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [sssp_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [sssp_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);
    import sssp_pkg::*;

    // Configuration registers
    logic [NCOUNT_BITS-1:0] r_node_count;
    logic [NODE_BITS-1:0]   r_source;

    // Sequencer
    logic [STEP_BITS-1:0] r_step;
    logic [STEP_BITS-1:0] n_step;
    t_ucode               ctl;
    logic                 jump;

    // Edge store and its bookkeeping
    t_edge                    edge_mem [MAX_EDGES];
    t_edge                    r_edge;
    logic [EDGE_CNT_BITS-1:0] r_edge_total;
    logic [EDGE_CNT_BITS-1:0] r_edge_idx;
    logic                     r_overflow;

    // Distance memory with two registered read ports, valid bits in flops
    logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
    logic [DIST_BITS-1:0] r_rd_a;
    logic [DIST_BITS-1:0] r_rd_b;
    logic [MAX_NODES-1:0] r_valid;
    logic                 dist_we;
    logic [NODE_BITS-1:0] dist_waddr;
    logic [DIST_BITS-1:0] dist_wdata;
    logic [NODE_BITS-1:0] rd_addr_a;

    // Relaxation datapath
    logic                 r_ab_hit;
    logic [DIST_BITS-1:0] r_cand;
    logic                 r_changed;
    logic [NODE_BITS-1:0] r_pass;
    logic [NODE_BITS-1:0] r_emit_idx;
    logic [DIST_BITS-1:0] from_b;
    logic [DIST_BITS-1:0] sum_base;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] cand;
    logic [DIST_BITS-1:0] to_val;
    logic                 from_vld;
    logic                 to_vld;
    logic                 hit;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_free;

    // Derived control terms
    logic [NCOUNT_BITS-1:0] n_eff;
    logic [NODE_BITS-1:0]   node_last;
    logic                   in_acc;
    logic                   run_acc;
    logic                   edge_acc;
    logic                   edge_in_range;
    logic                   src_in_range;
    logic                   skip_edge;

    always_comb begin
        if (r_node_count == '0) begin
            n_eff = NCOUNT_BITS'(1);
        end else if (r_node_count > NCOUNT_BITS'(MAX_NODES)) begin
            n_eff = NCOUNT_BITS'(MAX_NODES);
        end else begin
            n_eff = r_node_count;
        end
    end

    assign node_last     = NODE_BITS'(n_eff - NCOUNT_BITS'(1));
    assign ctl           = ucode_rom(r_step);
    assign o_in_ready    = ctl.in_rdy;
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = i_in_valid && o_in_ready;
    assign run_acc       = in_acc && (i_in_item.req_type == REQ_RUN);
    assign edge_acc      = in_acc && (i_in_item.req_type == REQ_EDGE);
    assign edge_in_range = ({1'b0, i_in_item.end_a} < n_eff)
                        && ({1'b0, i_in_item.end_b} < n_eff);
    assign src_in_range  = {1'b0, r_source} < n_eff;
    assign skip_edge     = ({1'b0, r_edge.a} >= n_eff) || ({1'b0, r_edge.b} >= n_eff);
    assign out_free      = !r_out_valid || i_out_ready;

    // Evaluate the jump condition of the current control word
    always_comb begin
        case (ctl.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_RUN:     jump = !run_acc;
            C_EDGES_DONE: jump = (r_edge_idx == r_edge_total);
            C_SKIP_EDGE:  jump = skip_edge;
            C_PASS_MORE:  jump = r_changed && (r_pass != node_last);
            C_OUT_BUSY:   jump = !out_free;
            C_EMIT_MORE:  jump = (r_emit_idx != node_last);
            default:      jump = 1'b0;
        endcase
        n_step = jump ? ctl.target : r_step + STEP_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
            r_source     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NODE_COUNT:  r_node_count <= i_cfg_data;
                CFG_SOURCE_NODE: r_source     <= i_cfg_data[NODE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Edge store: append on an in-range edge beat, read one entry per sweep step
    always_ff @(posedge i_clk) begin
        if (edge_acc && edge_in_range && !r_edge_total[EDGE_CNT_BITS-1]) begin
            edge_mem[r_edge_total[EDGE_IDX_BITS-1:0]] <=
                '{a: i_in_item.end_a, b: i_in_item.end_b, w: i_in_item.weight};
        end
        if (ctl.edge_rd) begin
            r_edge <= edge_mem[r_edge_idx[EDGE_IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
        end else if (ctl.finish) begin
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
        end else if (edge_acc && edge_in_range) begin
            // Store is full once the top count bit is set
            if (r_edge_total[EDGE_CNT_BITS-1]) begin
                r_overflow <= 1'b1;
            end else begin
                r_edge_total <= r_edge_total + EDGE_CNT_BITS'(1);
            end
        end
    end

    // Relax a->b on the first step, then b->a against the updated b distance.
    // One adder and comparator serve both directions.
    assign from_b   = r_ab_hit ? r_cand : r_rd_b;
    assign sum_base = ctl.relax_ab ? r_rd_a : from_b;
    assign sum      = {1'b0, sum_base} + (DIST_BITS+1)'(r_edge.w);
    assign cand     = sum[DIST_BITS] ? '1 : sum[DIST_BITS-1:0];
    assign to_val   = ctl.relax_ab ? r_rd_b : r_rd_a;
    assign from_vld = ctl.relax_ab ? r_valid[r_edge.a] : r_valid[r_edge.b];
    assign to_vld   = ctl.relax_ab ? r_valid[r_edge.b] : r_valid[r_edge.a];
    assign hit      = (ctl.relax_ab || ctl.relax_ba) && from_vld
                   && (!to_vld || (cand < to_val));

    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = r_edge.a;
        dist_wdata = cand;
        if (ctl.init) begin
            dist_we    = src_in_range;
            dist_waddr = r_source;
            dist_wdata = '0;
        end else if (hit) begin
            dist_we    = 1'b1;
            dist_waddr = ctl.relax_ab ? r_edge.b : r_edge.a;
        end
    end

    assign rd_addr_a = ctl.emit_rd ? r_emit_idx : r_edge.a;

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (ctl.dist_rd || ctl.emit_rd) begin
            r_rd_a <= dist_mem[rd_addr_a];
        end
        if (ctl.dist_rd) begin
            r_rd_b <= dist_mem[r_edge.b];
        end
        if (ctl.relax_ab) begin
            r_cand <= cand;
        end
    end

    // Valid bits, counters and pass bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_ab_hit   <= 1'b0;
            r_changed  <= 1'b0;
            r_pass     <= '0;
            r_edge_idx <= '0;
            r_emit_idx <= '0;
        end else begin
            if (ctl.init) begin
                // Only the source starts out reached, and only when in range
                r_valid    <= src_in_range ? (MAX_NODES'(1) << r_source) : '0;
                r_changed  <= 1'b0;
                r_pass     <= '0;
                r_edge_idx <= '0;
                r_emit_idx <= '0;
            end
            if (ctl.dist_rd) begin
                r_edge_idx <= r_edge_idx + EDGE_CNT_BITS'(1);
                r_ab_hit   <= 1'b0;
            end
            if (ctl.relax_ab) begin
                r_ab_hit <= hit;
            end
            if (hit) begin
                r_valid[dist_waddr] <= 1'b1;
                r_changed           <= 1'b1;
            end
            if (ctl.next_pass) begin
                r_pass     <= r_pass + NODE_BITS'(1);
                r_edge_idx <= '0;
                r_changed  <= 1'b0;
            end
            if (ctl.emit_inc) begin
                r_emit_idx <= r_emit_idx + NODE_BITS'(1);
            end
        end
    end

    // Output register: load a result beat when the slot is free, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit_ld && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit_ld && out_free) begin
            r_out_item.node_index     <= r_emit_idx;
            r_out_item.reachable      <= r_valid[r_emit_idx];
            r_out_item.distance       <= r_valid[r_emit_idx] ? r_rd_a : '0;
            r_out_item.store_overflow <= r_overflow;
            r_out_item.last_result    <= (r_emit_idx == node_last);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[sim/tb_single_source_shortest_path_core.sv]
module tb_single_source_shortest_path_core;

    timeunit 1ns;
    timeprecision 1ps;

    import sssp_pkg::*;

    // Longest single idle stretch either side may insert, and the long
    // receiver hold-off used to back the block up.
    localparam int unsigned GAP_CEIL   = 60;
    localparam int unsigned LONG_HOLD  = 500;
    localparam int unsigned DRAIN_WAIT = 16;
    localparam int unsigned ITEM_GOAL  = 430;
    localparam longint unsigned DIST_CEIL = (64'd1 << DIST_BITS) - 1;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    t_in_item                 in_item = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_item                out_item;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    single_source_shortest_path_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Request beats waiting for the driver, and distance results the
    // block still owes us, oldest first.
    t_in_item  pending_reqs[$];
    t_out_item owed_distances[$];

    // Shadow of the block: configuration, edge store and distance table.
    logic [NCOUNT_BITS-1:0] shadow_node_count = NODE_COUNT_RESET;
    logic [NODE_BITS-1:0]   shadow_source = '0;
    logic [NODE_BITS-1:0]   stored_a [MAX_EDGES];
    logic [NODE_BITS-1:0]   stored_b [MAX_EDGES];
    int unsigned            stored_w [MAX_EDGES];
    int unsigned            stored_total = 0;
    bit                     store_full = 1'b0;
    bit                     node_reach [MAX_NODES];
    int unsigned            node_dist [MAX_NODES];

    // Bookkeeping.
    bit          in_taken = 1'b0;
    bit          idle_stretch = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_served = 1'b0;
    int unsigned hold_left = 0;
    int unsigned tx_gap_left = 0;
    int unsigned rx_gap_left = 0;
    int unsigned error_count = 0;
    int unsigned edge_beats = 0;
    int unsigned run_beats = 0;
    int unsigned result_beats = 0;
    int unsigned overflow_runs = 0;
    int unsigned setting_writes = 0;
    int unsigned items_queued = 0;
    int unsigned edges_since_run = 0;
    longint unsigned cycle_budget = 0;
    longint unsigned cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, GAP_CEIL);
    endfunction

    // Node count as the block sees it: zero acts as one, anything past the
    // node limit acts as the limit.
    function automatic int unsigned active_nodes();
        if (shadow_node_count == 0) return 1;
        if (shadow_node_count > MAX_NODES) return MAX_NODES;
        return shadow_node_count;
    endfunction

    function automatic bit relax_arc(int unsigned from, int unsigned to, int unsigned w);
        longint unsigned cand;
        if (!node_reach[from]) return 1'b0;
        cand = node_dist[from];
        cand += w;
        if (cand > DIST_CEIL) cand = DIST_CEIL;
        if (!node_reach[to] || cand < node_dist[to]) begin
            node_reach[to] = 1'b1;
            node_dist[to] = 32'(cand);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted request to the shadow; a run queues one owed
    // distance per node in index order and empties the edge store.
    function automatic void apply_request(t_in_item req);
        int unsigned n;
        int unsigned pass;
        int unsigned i;
        bit          changed;
        t_out_item   res;
        n = active_nodes();
        if (req.req_type == REQ_EDGE) begin
            edge_beats++;
            if (req.end_a >= n || req.end_b >= n) return;
            if (stored_total >= MAX_EDGES) begin
                store_full = 1'b1;
                return;
            end
            stored_a[stored_total] = req.end_a;
            stored_b[stored_total] = req.end_b;
            stored_w[stored_total] = req.weight;
            stored_total++;
            return;
        end
        run_beats++;
        for (i = 0; i < MAX_NODES; i++) begin
            node_reach[i] = 1'b0;
            node_dist[i] = 0;
        end
        if (shadow_source < n) begin
            node_reach[shadow_source] = 1'b1;
            for (pass = 0; pass < n; pass++) begin
                changed = 1'b0;
                for (i = 0; i < stored_total; i++) begin
                    if (stored_a[i] >= n || stored_b[i] >= n) continue;
                    if (relax_arc(stored_a[i], stored_b[i], stored_w[i])) changed = 1'b1;
                    if (relax_arc(stored_b[i], stored_a[i], stored_w[i])) changed = 1'b1;
                end
                if (!changed) break;
            end
        end
        if (store_full) overflow_runs++;
        for (i = 0; i < n; i++) begin
            res.node_index     = NODE_BITS'(i);
            res.reachable      = node_reach[i];
            res.distance       = node_reach[i] ? DIST_BITS'(node_dist[i]) : '0;
            res.store_overflow = store_full;
            res.last_result    = (i + 1 == n);
            owed_distances.insert(owed_distances.size(), res);
        end
        stored_total = 0;
        store_full = 1'b0;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            error_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Queue helpers. Each one also grows the cycle budget by the slowest
    // legal time the block and both idling sides could take for the beat.
    function automatic void queue_edge(int unsigned a, int unsigned b, int unsigned w);
        t_in_item req;
        req.req_type = REQ_EDGE;
        req.end_a    = NODE_BITS'(a);
        req.end_b    = NODE_BITS'(b);
        req.weight   = WEIGHT_BITS'(w);
        pending_reqs.insert(pending_reqs.size(), req);
        items_queued++;
        edges_since_run++;
        cycle_budget += GAP_CEIL + 2;
    endfunction

    function automatic void queue_run();
        t_in_item    req;
        int unsigned n;
        int unsigned stored;
        req.req_type = REQ_RUN;
        req.end_a    = NODE_BITS'($urandom);
        req.end_b    = NODE_BITS'($urandom);
        req.weight   = WEIGHT_BITS'($urandom);
        pending_reqs.insert(pending_reqs.size(), req);
        items_queued++;
        n = active_nodes();
        stored = (edges_since_run > MAX_EDGES) ? MAX_EDGES : edges_since_run;
        cycle_budget += 4 + n * (2 + 4 * stored) + n * (3 + GAP_CEIL + 2);
        edges_since_run = 0;
    endfunction

    function automatic int unsigned pick_node(int unsigned n);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, MAX_NODES - 1);
        return $urandom_range(0, n - 1);
    endfunction

    function automatic int unsigned pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return (1 << WEIGHT_BITS) - 1;
        if (r < 60) return $urandom_range(1, 20);
        return $urandom_range(0, (1 << WEIGHT_BITS) - 1);
    endfunction

    // Write one register on the configuration channel and mirror it.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_NODE_COUNT) begin
            shadow_node_count = data;
        end else begin
            shadow_source = data[NODE_BITS-1:0];
        end
        setting_writes++;
        cycle_budget += 10;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every queued beat is in and every owed distance has
    // come back, then give the sequencer time to finish its clear-down.
    task automatic settle();
        while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
        while (owed_distances.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cycle_budget += 200;
    endtask

    // Request driver: advance to the next beat only once the current one
    // has been taken, inserting random gaps between beats.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (tx_gap_left > 0) begin
                in_valid    <= 1'b0;
                tx_gap_left <= tx_gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                in_item     <= pending_reqs.pop_front();
                in_valid    <= 1'b1;
                tx_gap_left <= idle_stretch ? 0 : pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on
    // request so the block backs up and drops its input ready.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            out_ready   <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= 1'b1;
        end else if (rx_gap_left > 0) begin
            out_ready   <= 1'b0;
            rx_gap_left <= rx_gap_left - 1;
        end else begin
            out_ready   <= 1'b1;
            rx_gap_left <= idle_stretch ? 0 : pick_gap();
        end
    end

    // Monitor: sample both channels on the rising edge. Predict on every
    // accepted request beat, check every accepted result beat against the
    // oldest owed distance.
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) apply_request(in_item);
            if (out_valid && out_ready) begin
                result_beats++;
                if (owed_distances.size() == 0) begin
                    error_count++;
                    $error("unexpected result beat for node %0d", out_item.node_index);
                end else begin
                    want = owed_distances.pop_front();
                    check_field("node_index", want.node_index, out_item.node_index);
                    check_field("reachable", want.reachable, out_item.reachable);
                    check_field("distance", want.distance, out_item.distance);
                    check_field("store_overflow", want.store_overflow,
                                out_item.store_overflow);
                    check_field("last_result", want.last_result, out_item.last_result);
                end
            end
        end
    end

    // Watchdog: budget is a worst-case bound on the stimulus queued so far.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 4 * cycle_budget + 20000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned seqs;
        int unsigned s;
        int unsigned k;
        int unsigned j;
        int unsigned r;
        int unsigned tmp;
        int unsigned chain_order [MAX_NODES];
        logic [CFG_DATA_BITS-1:0] nc_pick;

        cycle_budget = 1000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: run on an empty store, then a small graph with a
        // zero-weight edge, a self loop and a duplicate pair.
        queue_run();
        queue_edge(0, 63, 16'hFFFF);
        queue_edge(63, 1, 0);
        queue_edge(1, 1, 5);
        queue_edge(2, 3, 7);
        queue_edge(3, 2, 4);
        queue_edge(1, 2, 0);
        queue_run();
        settle();

        // Single node: the edge to node 1 is out of range and is dropped.
        write_register(CFG_NODE_COUNT, 7'd1);
        write_register(CFG_SOURCE_NODE, 7'd0);
        queue_edge(0, 0, 9);
        queue_edge(0, 1, 3);
        queue_run();
        settle();

        // Zero node count acts as one; source beyond it leaves node 0 unreached.
        write_register(CFG_NODE_COUNT, 7'd0);
        write_register(CFG_SOURCE_NODE, 7'd5);
        queue_run();
        settle();

        // Oversized node count acts as the limit; top source node.
        write_register(CFG_NODE_COUNT, 7'd127);
        write_register(CFG_SOURCE_NODE, 7'd63);
        queue_edge(63, 62, 1);
        queue_edge(62, 0, 16'hFFFF);
        queue_run();
        settle();

        // Store edges through node 40, then shrink the node count so the
        // run has to skip them.
        write_register(CFG_NODE_COUNT, 7'd64);
        write_register(CFG_SOURCE_NODE, 7'd0);
        queue_edge(0, 40, 1);
        queue_edge(40, 5, 1);
        queue_edge(0, 5, 100);
        settle();
        write_register(CFG_NODE_COUNT, 7'd20);
        queue_edge(5, 6, 2);
        queue_run();
        settle();

        // Back-pressure: hold the receiver off while requests keep coming.
        write_register(CFG_NODE_COUNT, 7'd64);
        hold_request = 1'b1;
        cycle_budget += LONG_HOLD;
        for (j = 0; j < 4; j++) queue_edge(pick_node(64), pick_node(64), pick_weight());
        queue_run();
        for (j = 0; j < 6; j++) queue_edge(pick_node(64), pick_node(64), pick_weight());
        queue_run();
        settle();

        // Overfill the edge store so the run reports the overflow.
        write_register(CFG_SOURCE_NODE, 7'($urandom_range(0, 63)));
        for (j = 0; j < MAX_EDGES + 6; j++) begin
            queue_edge(pick_node(64), pick_node(64), pick_weight());
        end
        queue_run();
        settle();

        // Longest possible path: a 64-node chain of full weights, loaded in
        // shuffled order so the sweeps take several passes.
        write_register(CFG_SOURCE_NODE, 7'd0);
        for (j = 0; j < MAX_NODES - 1; j++) chain_order[j] = j;
        for (j = MAX_NODES - 2; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = chain_order[j];
            chain_order[j] = chain_order[k];
            chain_order[k] = tmp;
        end
        idle_stretch = 1'b1;
        for (j = 0; j < MAX_NODES - 1; j++) begin
            queue_edge(chain_order[j], chain_order[j] + 1, 16'hFFFF);
        end
        queue_run();
        settle();

        // Random phases: new settings, then a few edge bursts each closed
        // by a run; now and then a burst is left standing across the next
        // settings change.
        while (items_queued < ITEM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 60) nc_pick = 7'($urandom_range(2, 16));
            else if (r < 85) nc_pick = 7'($urandom_range(17, 64));
            else if (r < 93) nc_pick = 7'd64;
            else if (r < 97) nc_pick = 7'($urandom_range(0, 1));
            else nc_pick = 7'($urandom_range(65, 127));
            write_register(CFG_NODE_COUNT, nc_pick);
            n = active_nodes();
            if ($urandom_range(0, 99) < 85) begin
                write_register(CFG_SOURCE_NODE, 7'($urandom_range(0, n - 1)));
            end else begin
                write_register(CFG_SOURCE_NODE, 7'($urandom_range(0, 127)));
            end
            idle_stretch = ($urandom_range(0, 3) == 0);
            seqs = $urandom_range(1, 3);
            for (s = 0; s < seqs; s++) begin
                k = $urandom_range(0, (n < 24) ? n + 2 : 24);
                for (j = 0; j < k; j++) queue_edge(pick_node(n), pick_node(n), pick_weight());
                if ($urandom_range(0, 9) != 0) queue_run();
            end
            settle();
        end

        // Close any edges still standing so every stored edge is exercised.
        queue_run();
        settle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d edge beats and %0d runs (%0d with an overfilled store)",
                 edge_beats, run_beats, overflow_runs);
        $display("Checked %0d result beats over %0d register writes, %0d errors",
                 result_beats, setting_writes, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[single_source_shortest_path_core.f]
hw/rtl/sssp_pkg.sv
hw/rtl/single_source_shortest_path_core.sv
sim/tb_single_source_shortest_path_core.sv
